// ===== hdl/aaclc_pkg.sv =====
// ----------------------------------------------------------------------------
// aaclc_pkg - shared types and constants for the AAC-LC config checker
// Register indexes, reset values, field codes and the sample rate table.
// ----------------------------------------------------------------------------
package aaclc_pkg;

	localparam int RATE_W = 24;
	localparam int CHAN_W = 4;
	localparam int CFG_W  = RATE_W;

	// configuration register indexes
	localparam logic CFG_IDX_RATE     = 1'b0;
	localparam logic CFG_IDX_CHANNELS = 1'b1;

	localparam logic [RATE_W-1:0] RATE_RESET     = 24'd48000;
	localparam logic [CHAN_W-1:0] CHANNELS_RESET = 4'd2;

	// field codes
	localparam logic [4:0]  OBJ_TYPE_LC       = 5'd2;
	localparam logic [3:0]  FREQ_IDX_EXPLICIT = 4'd15;
	localparam logic [3:0]  FREQ_IDX_RESERVED = 4'd13;  // 13 and 14 are reserved; 15 is the explicit rate escape
	localparam logic [10:0] SYNC_WORD         = 11'h2b7;
	localparam logic [4:0]  EXT_TYPE_SBR      = 5'd5;

	// field lengths in bits
	localparam logic [4:0] LEN_OBJ_TYPE = 5'd5;
	localparam logic [4:0] LEN_FREQ_IDX = 5'd4;
	localparam logic [4:0] LEN_RATE     = 5'd24;
	localparam logic [4:0] LEN_CHAN     = 5'd4;
	localparam logic [4:0] LEN_SYNC     = 5'd11;
	localparam logic [4:0] LEN_EXT_TYPE = 5'd5;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [CHAN_W-1:0] channels;
	} cfg_t;

	// sample rate for a table index; reserved indexes give zero
	function automatic logic [RATE_W-1:0] rate_lookup(input logic [3:0] idx);
		logic [RATE_W-1:0] r;
		case (idx)
			4'd0:    r = 24'd96000;
			4'd1:    r = 24'd88200;
			4'd2:    r = 24'd64000;
			4'd3:    r = 24'd48000;
			4'd4:    r = 24'd44100;
			4'd5:    r = 24'd32000;
			4'd6:    r = 24'd24000;
			4'd7:    r = 24'd22050;
			4'd8:    r = 24'd16000;
			4'd9:    r = 24'd12000;
			4'd10:   r = 24'd11025;
			4'd11:   r = 24'd8000;
			4'd12:   r = 24'd7350;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/aaclc_fifo.sv =====
// ----------------------------------------------------------------------------
// aaclc_fifo - small register queue
// Decouples the byte front end from the parser and the parser from the
// result consumer. Push and pop may both happen in one cycle.
// ----------------------------------------------------------------------------
module aaclc_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/aaclc_parser.sv =====
// ----------------------------------------------------------------------------
// aaclc_parser - bit field machine, one byte per cycle unless stalled
// Runs eight bit steps of the field machine on each byte and writes a
// pass/fail item into the result queue on a last byte (stalled while full).
// ----------------------------------------------------------------------------
module aaclc_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aaclc_pkg::cfg_t      cfg,
	input  logic [7:0]           in_data,
	input  logic                 in_last,
	input  logic                 in_empty,
	output logic                 in_pop,
	input  logic                 out_full,
	output logic                 out_push,
	output logic                 out_ok
);

	typedef enum logic [2:0] {
		PH_OBJTYPE, PH_FREQIDX, PH_RATE, PH_CHAN,
		PH_FLAG0, PH_FLAG1, PH_FLAG2, PH_TAIL
	} phase_t;

	typedef enum logic [2:0] {
		EX_SYNC, EX_TYPE, EX_SBR, EX_ZEROS, EX_BAD
	} ext_t;

	typedef struct packed {
		phase_t                         phase;
		logic [4:0]                     bits;
		logic [aaclc_pkg::RATE_W-1:0]   value;
		logic                           failed;
		logic                           tail_zero;
		ext_t                           ext;
	} pstate_t;

	localparam pstate_t PSTATE_CLEAR = '{
		phase: PH_OBJTYPE, bits: '0, value: '0,
		failed: 1'b0, tail_zero: 1'b1, ext: EX_SYNC
	};

	function automatic pstate_t bit_step(input pstate_t s, input logic b,
			input aaclc_pkg::cfg_t c);
		pstate_t n;
		logic [aaclc_pkg::RATE_W-1:0] sh;
		logic [4:0] nb;
		n  = s;
		sh = {s.value[aaclc_pkg::RATE_W-2:0], b};
		nb = s.bits + 5'd1;
		if (!s.failed) begin
			if (s.phase == PH_TAIL) begin
				if (b) n.tail_zero = 1'b0;
				case (s.ext)
					EX_SYNC: begin
						n.value = sh;
						n.bits  = nb;
						if (nb == aaclc_pkg::LEN_SYNC) begin
							n.ext   = (sh[10:0] == aaclc_pkg::SYNC_WORD) ? EX_TYPE : EX_BAD;
							n.bits  = '0;
							n.value = '0;
						end
					end
					EX_TYPE: begin
						n.value = sh;
						n.bits  = nb;
						if (nb == aaclc_pkg::LEN_EXT_TYPE) begin
							n.ext   = (sh[4:0] == aaclc_pkg::EXT_TYPE_SBR) ? EX_SBR : EX_BAD;
							n.bits  = '0;
							n.value = '0;
						end
					end
					EX_SBR:   n.ext = b ? EX_BAD : EX_ZEROS;
					EX_ZEROS: if (b) n.ext = EX_BAD;
					default:  n.ext = s.ext;
				endcase
			end else begin
				n.value = sh;
				n.bits  = nb;
				case (s.phase)
					PH_OBJTYPE: begin
						if (nb == aaclc_pkg::LEN_OBJ_TYPE) begin
							if (sh != {19'd0, aaclc_pkg::OBJ_TYPE_LC}) n.failed = 1'b1;
							n.phase = PH_FREQIDX;
							n.bits  = '0;
							n.value = '0;
						end
					end
					PH_FREQIDX: begin
						if (nb == aaclc_pkg::LEN_FREQ_IDX) begin
							n.bits  = '0;
							n.value = '0;
							if (sh[3:0] == aaclc_pkg::FREQ_IDX_EXPLICIT) begin
								n.phase = PH_RATE;
							end else begin
								n.phase = PH_CHAN;
								if (sh[3:0] >= aaclc_pkg::FREQ_IDX_RESERVED ||
										aaclc_pkg::rate_lookup(sh[3:0]) != c.rate) begin
									n.failed = 1'b1;
								end
							end
						end
					end
					PH_RATE: begin
						if (nb == aaclc_pkg::LEN_RATE) begin
							if (sh != c.rate) n.failed = 1'b1;
							n.phase = PH_CHAN;
							n.bits  = '0;
							n.value = '0;
						end
					end
					PH_CHAN: begin
						if (nb == aaclc_pkg::LEN_CHAN) begin
							if (sh[3:0] != c.channels) n.failed = 1'b1;
							n.phase = PH_FLAG0;
							n.bits  = '0;
							n.value = '0;
						end
					end
					PH_FLAG0, PH_FLAG1, PH_FLAG2: begin
						if (b) n.failed = 1'b1;
						n.phase = phase_t'(s.phase + 3'd1);
						n.bits  = '0;
						n.value = '0;
					end
					default: n.failed = 1'b1;
				endcase
			end
		end
		return n;
	endfunction

	pstate_t st_q;
	pstate_t st_step [9];

	// eight bit steps, MSB first
	always_comb begin
		st_step[0] = st_q;
		for (int i = 0; i < 8; i++) begin
			st_step[i+1] = bit_step(st_step[i], in_data[7-i], cfg);
		end
	end

	// a non-last byte never needs result space
	assign in_pop   = !in_empty && (!in_last || !out_full);
	assign out_push = in_pop && in_last;
	assign out_ok   = !st_step[8].failed && (st_step[8].phase == PH_TAIL) &&
	                  (st_step[8].tail_zero || st_step[8].ext == EX_ZEROS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PSTATE_CLEAR;
		end else if (in_pop) begin
			st_q <= in_last ? PSTATE_CLEAR : st_step[8];
		end
	end

endmodule

// ===== hdl/aac_lc_config_checker.sv =====
// ----------------------------------------------------------------------------
// aac_lc_config_checker - AAC-LC AudioSpecificConfig checker
// Checks a byte stream against the exact AAC-LC profile set by two registers.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel is a queue: an item (data_byte, last_byte) is taken at a
//    clock edge with push high and full low. Bits are used MSB first.
//  - Result channel is a queue: while empty is low, config_ok shows the
//    oldest result; it is taken at an edge with pop high. One result item
//    comes per item marked last_byte, none for other items.
//  - Config: cfg_we writes cfg_data into register cfg_index (0: expected
//    sample rate, 24 bits; 1: expected channel config, low 4 bits). Write
//    only while the block is idle.
//  - Throughput: one item per cycle unless stalled as below. The parser runs
//    all eight bit steps of a byte in the cycle it leaves the input queue.
//  - Result path: input queue, parser, then result queue onto config_ok.
//  - Stall: while the result queue is full the parser stops at the next
//    last byte; the input queue then fills and full rises. Non-last bytes
//    keep flowing into the parser meanwhile.
//  - Reset: queues empty, parse state cleared, registers back to 48000 Hz
//    and two channels. No clearing pass is needed.
// ----------------------------------------------------------------------------
module aac_lc_config_checker #(
	parameter int IN_DEPTH  = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [aaclc_pkg::CFG_W-1:0]   cfg_data,
	// byte input
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	// result output
	input  logic                          pop,
	output logic                          empty,
	output logic                          config_ok
);

	aaclc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate     <= aaclc_pkg::RATE_RESET;
			cfg_q.channels <= aaclc_pkg::CHANNELS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				aaclc_pkg::CFG_IDX_RATE:     cfg_q.rate     <= cfg_data;
				aaclc_pkg::CFG_IDX_CHANNELS: cfg_q.channels <= cfg_data[aaclc_pkg::CHAN_W-1:0];
				default:                     cfg_q          <= cfg_q;
			endcase
		end
	end

	// front: byte queue
	logic [7:0] q_data;
	logic       q_last, q_empty, q_pop;

	aaclc_fifo #(
		.WIDTH(9),
		.DEPTH(IN_DEPTH)
	) u_in_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data({last_byte, data_byte}),
		.full   (full),
		.pop    (q_pop),
		.rd_data({q_last, q_data}),
		.empty  (q_empty)
	);

	// back: field machine
	logic r_full, r_push, r_ok;

	aaclc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_data (q_data),
		.in_last (q_last),
		.in_empty(q_empty),
		.in_pop  (q_pop),
		.out_full(r_full),
		.out_push(r_push),
		.out_ok  (r_ok)
	);

	// result queue decouples the consumer
	aaclc_fifo #(
		.WIDTH(1),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (r_push),
		.wr_data(r_ok),
		.full   (r_full),
		.pop    (pop),
		.rd_data(config_ok),
		.empty  (empty)
	);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the AAC-LC config checker
// Feeds AudioSpecificConfig byte streams through the queue ports: a short
// directed list, then random streams under several register settings.
// Each config_ok is checked against a directed row's typed verdict, else a
// bit-serial parser on accepted items. Handshakes stall at random, bar one phase.
// ----------------------------------------------------------------------------
module tb_top;

	// field machine positions of the parser
	typedef enum logic [3:0] {
		FLD_OBJ, FLD_FREQ, FLD_RATE, FLD_CHAN, FLD_FLAG0, FLD_FLAG1, FLD_FLAG2, FLD_TAIL
	} field_e;

	// progress through the optional SBR extension in the tail
	typedef enum logic [2:0] {
		EXT_SYNC, EXT_TYPE, EXT_SBR, EXT_ZEROS, EXT_BAD
	} ext_e;

	// one row of the directed list: the item plus an optional typed verdict
	typedef struct packed {
		logic [7:0] d;
		logic       last;
		logic       typed;
		logic       ok;
	} stim_row_t;

	localparam int N_DIRECTED  = 25;
	localparam int PHASE_BYTES = 135;
	localparam int SETTLE      = 4;       // cycles past the last verdict before a write
	localparam int LIMIT_NS    = 2000000; // far beyond the slowest legal run

	localparam logic [23:0] STD_RATES [13] = '{
		24'd96000, 24'd88200, 24'd64000, 24'd48000, 24'd44100, 24'd32000, 24'd24000,
		24'd22050, 24'd16000, 24'd12000, 24'd11025, 24'd8000, 24'd7350
	};

	// Directed streams, each ending on a last item:
	//   48 kHz stereo AAC-LC (passes at reset settings), lone zero byte,
	//   lone all-ones byte, reserved frequency indexes 13 and 14, wrong object
	//   type followed by junk, explicit 24-bit rate of 48000, SBR extension
	//   with zero padding, and the same extension cut before its SBR bit.
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{8'h11, 1'b0, 1'b0, 1'b0}, '{8'h90, 1'b1, 1'b1, 1'b1},
		'{8'h00, 1'b1, 1'b1, 1'b0},
		'{8'hff, 1'b1, 1'b1, 1'b0},
		'{8'h16, 1'b0, 1'b0, 1'b0}, '{8'h90, 1'b1, 1'b1, 1'b0},
		'{8'h17, 1'b0, 1'b0, 1'b0}, '{8'h10, 1'b1, 1'b1, 1'b0},
		'{8'h09, 1'b0, 1'b0, 1'b0}, '{8'hff, 1'b0, 1'b0, 1'b0}, '{8'hff, 1'b1, 1'b0, 1'b0},
		'{8'h17, 1'b0, 1'b0, 1'b0}, '{8'h80, 1'b0, 1'b0, 1'b0}, '{8'h5d, 1'b0, 1'b0, 1'b0},
		'{8'hc0, 1'b0, 1'b0, 1'b0}, '{8'h10, 1'b1, 1'b0, 1'b0},
		'{8'h11, 1'b0, 1'b0, 1'b0}, '{8'h90, 1'b0, 1'b0, 1'b0}, '{8'h56, 1'b0, 1'b0, 1'b0},
		'{8'he5, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0, 1'b0},
		'{8'h11, 1'b0, 1'b0, 1'b0}, '{8'h90, 1'b0, 1'b0, 1'b0}, '{8'h56, 1'b0, 1'b0, 1'b0},
		'{8'he5, 1'b1, 1'b0, 1'b0}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic                        cfg_index;
	logic [aaclc_pkg::CFG_W-1:0] cfg_data;
	logic                        push;
	logic                        full;
	logic [7:0]                  data_byte;
	logic                        last_byte;
	logic                        pop;
	logic                        empty;
	logic                        config_ok;

	aac_lc_config_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.pop       (pop),
		.empty     (empty),
		.config_ok (config_ok)
	);

	// 4 ns period
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ------------------------------------------------------------------
	// Parser mirror: register copies and bit-serial parse state
	// ------------------------------------------------------------------
	logic [aaclc_pkg::RATE_W-1:0] want_rate;
	logic [aaclc_pkg::CHAN_W-1:0] want_chans;

	field_e            fld;
	logic [4:0]        nbits;
	logic [23:0]       acc;
	logic [23:0]       rate_seen;
	logic              tail_zero;
	ext_e              ext;
	logic              bad;

	logic              verdict_q [$];  // config_ok values still to come out
	bit                bitq [$];       // stream under construction, one bit each
	logic [7:0]        msg_q [$];      // the same stream packed into items

	int mismatches;
	int verdicts_seen;
	int verdicts_ok;
	int bytes_sent;
	int pop_hold;
	bit calm;                          // no idling on either side while set

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	function automatic void clear_parse();
		fld       = FLD_OBJ;
		nbits     = '0;
		acc       = '0;
		rate_seen = '0;
		tail_zero = 1'b1;
		ext       = EXT_SYNC;
		bad       = 1'b0;
	endfunction

	function automatic void enter_field(input field_e f);
		fld   = f;
		nbits = '0;
		acc   = '0;
	endfunction

	// tail after the flags: all zero, or sync / SBR type / SBR-present 0 / zeros
	function automatic void tail_step(input logic b);
		if (b)
			tail_zero = 1'b0;
		case (ext)
			EXT_SYNC: begin
				acc   = {acc[22:0], b};
				nbits = nbits + 5'd1;
				if (nbits == aaclc_pkg::LEN_SYNC) begin
					ext   = (acc == 24'(aaclc_pkg::SYNC_WORD)) ? EXT_TYPE : EXT_BAD;
					nbits = '0;
					acc   = '0;
				end
			end
			EXT_TYPE: begin
				acc   = {acc[22:0], b};
				nbits = nbits + 5'd1;
				if (nbits == aaclc_pkg::LEN_EXT_TYPE) begin
					ext   = (acc == 24'(aaclc_pkg::EXT_TYPE_SBR)) ? EXT_SBR : EXT_BAD;
					nbits = '0;
					acc   = '0;
				end
			end
			EXT_SBR:   ext = b ? EXT_BAD : EXT_ZEROS;
			EXT_ZEROS: if (b) ext = EXT_BAD;
			default:   ;
		endcase
	endfunction

	function automatic void parse_bit(input logic b);
		if (bad)
			return;   // once a field fails, the rest is ignored until last
		if (fld == FLD_TAIL) begin
			tail_step(b);
			return;
		end
		acc   = {acc[22:0], b};
		nbits = nbits + 5'd1;
		case (fld)
			FLD_OBJ: if (nbits == aaclc_pkg::LEN_OBJ_TYPE) begin
				if (acc != 24'(aaclc_pkg::OBJ_TYPE_LC))
					bad = 1'b1;
				enter_field(FLD_FREQ);
			end
			FLD_FREQ: if (nbits == aaclc_pkg::LEN_FREQ_IDX) begin
				if (acc[3:0] == aaclc_pkg::FREQ_IDX_EXPLICIT) begin
					enter_field(FLD_RATE);
				end else if (acc[3:0] >= aaclc_pkg::FREQ_IDX_RESERVED) begin
					bad = 1'b1;
					enter_field(FLD_CHAN);
				end else begin
					rate_seen = STD_RATES[acc[3:0]];
					if (rate_seen != want_rate)
						bad = 1'b1;
					enter_field(FLD_CHAN);
				end
			end
			FLD_RATE: if (nbits == aaclc_pkg::LEN_RATE) begin
				rate_seen = acc;
				if (rate_seen != want_rate)
					bad = 1'b1;
				enter_field(FLD_CHAN);
			end
			FLD_CHAN: if (nbits == aaclc_pkg::LEN_CHAN) begin
				if (acc[3:0] != want_chans)
					bad = 1'b1;
				enter_field(FLD_FLAG0);
			end
			FLD_FLAG0, FLD_FLAG1, FLD_FLAG2: begin
				if (b)
					bad = 1'b1;
				enter_field(field_e'(fld + 4'd1));
			end
			default: bad = 1'b1;
		endcase
	endfunction

	// returns 1 when the item closes a config; verdict then holds config_ok
	function automatic bit parse_byte(input logic [7:0] d, input logic l, output logic verdict);
		for (int i = 7; i >= 0; i--)
			parse_bit(d[i]);
		verdict = 1'b0;
		if (!l)
			return 0;
		verdict = !bad && fld == FLD_TAIL && (tail_zero || ext == EXT_ZEROS);
		clear_parse();
		return 1;
	endfunction

	// ------------------------------------------------------------------
	// Handshake helpers
	// ------------------------------------------------------------------

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (calm || r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// drive one item, wait for it to be taken, then log its verdict if any
	task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
			input logic typed_ok);
		int gap;
		logic v;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bytes_sent++;
		if (parse_byte(d, l, v))
			verdict_q.push_back(typed ? typed_ok : v);
	endtask

	// stop sending and let every pending verdict drain out
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [aaclc_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// new expected profile; junk above bit 3 of the channel write must be dropped
	task automatic set_profile(input logic [aaclc_pkg::RATE_W-1:0] r,
			input logic [aaclc_pkg::CHAN_W-1:0] c);
		logic [aaclc_pkg::CFG_W-1:0] chan_word;
		chan_word = {20'($urandom), c};
		drain();
		write_reg(aaclc_pkg::CFG_IDX_RATE, r);
		write_reg(aaclc_pkg::CFG_IDX_CHANNELS, chan_word);
		want_rate  = r;
		want_chans = chan_word[aaclc_pkg::CHAN_W-1:0];
	endtask

	// ------------------------------------------------------------------
	// Random stream builder
	// ------------------------------------------------------------------
	function automatic void put_bits(input logic [23:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			bitq.push_back(v[i]);
	endfunction

	// Mostly well-formed AAC-LC headers with random content, plus a share of
	// noise, wrong fields, broken extensions and cut-short streams.
	task automatic random_stream();
		int          kind;
		int          std_idx;
		int          k;
		int          cut;
		logic [3:0]  fidx;
		logic [16:0] ext17;
		logic [7:0]  b;
		bit          junk_pad;
		bitq.delete();
		msg_q.delete();
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			k = $urandom_range(1, 6);
			repeat (k) msg_q.push_back(8'($urandom));
		end else begin
			put_bits(($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 31))
				: 24'(aaclc_pkg::OBJ_TYPE_LC), 5);

			std_idx = -1;
			for (int i = 0; i < 13; i++)
				if (STD_RATES[i] == want_rate)
					std_idx = i;
			k = $urandom_range(0, 9);
			if (k < 5 && std_idx >= 0)
				fidx = 4'(std_idx);
			else if (k < 8)
				fidx = aaclc_pkg::FREQ_IDX_EXPLICIT;
			else
				fidx = 4'($urandom_range(0, 15));
			put_bits(24'(fidx), 4);
			if (fidx == aaclc_pkg::FREQ_IDX_EXPLICIT)
				put_bits(($urandom_range(0, 4) == 0) ? 24'($urandom) : want_rate, 24);

			put_bits(($urandom_range(0, 6) == 0) ? 24'($urandom_range(0, 15))
				: 24'(want_chans), 4);
			put_bits(($urandom_range(0, 6) == 0) ? 24'($urandom_range(0, 7)) : 24'd0, 3);

			ext17 = {aaclc_pkg::SYNC_WORD, aaclc_pkg::EXT_TYPE_SBR, 1'b0};
			case ($urandom_range(0, 5))
				0: ;                                     // header only
				1: put_bits(24'd0, $urandom_range(0, 20));
				2: begin                                 // extension, sometimes one bit off
					if ($urandom_range(0, 4) == 0)
						ext17 = ext17 ^ (17'd1 << $urandom_range(0, 16));
					put_bits(24'(ext17), 17);
					put_bits(24'd0, $urandom_range(0, 10));
				end
				3: put_bits(24'($urandom), $urandom_range(1, 24));
				4: begin                                 // stray one after the extension
					put_bits(24'(ext17), 17);
					put_bits(24'd0, $urandom_range(0, 6));
					put_bits(24'd1, 1);
				end
				default: begin                           // extension cut short
					k = $urandom_range(1, 16);
					put_bits(24'(ext17 >> (17 - k)), k);
				end
			endcase

			junk_pad = ($urandom_range(0, 9) == 0);
			while (bitq.size() % 8 != 0)
				bitq.push_back(junk_pad ? 1'($urandom) : 1'b0);
			while (bitq.size() != 0) begin
				for (int i = 7; i >= 0; i--)
					b[i] = bitq.pop_front();
				msg_q.push_back(b);
			end

			// truncated stream
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, msg_q.size());
				while (msg_q.size() > cut)
					void'(msg_q.pop_back());
			end
		end
		for (int i = 0; i < msg_q.size(); i++)
			send_byte(msg_q[i], i == msg_q.size() - 1, 1'b0, 1'b0);
	endtask

	task automatic random_phase();
		int phase_bytes;
		phase_bytes = 0;
		while (phase_bytes < PHASE_BYTES) begin
			random_stream();
			phase_bytes += msg_q.size();
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random pop stalls, check at the rising edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else begin
			pop <= 1'b1;
			if ($urandom_range(0, 2) == 0)
				pop_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("config_ok=%0b with no verdict pending", config_ok));
			end else begin
				if (config_ok !== verdict_q[0])
					report_mismatch($sformatf("config_ok=%0b, predicted %0b",
						config_ok, verdict_q[0]));
				verdicts_seen++;
				if (verdict_q[0])
					verdicts_ok++;
				void'(verdict_q.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = aaclc_pkg::CFG_IDX_RATE;
		cfg_data      = '0;
		push          = 1'b0;
		data_byte     = '0;
		last_byte     = 1'b0;
		pop           = 1'b0;
		pop_hold      = 0;
		calm          = 1'b0;
		mismatches    = 0;
		verdicts_seen = 0;
		verdicts_ok   = 0;
		bytes_sent    = 0;
		want_rate     = aaclc_pkg::RATE_RESET;
		want_chans    = aaclc_pkg::CHANNELS_RESET;
		clear_parse();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed list at the reset profile (48 kHz, two channels)
		for (int i = 0; i < N_DIRECTED; i++)
			send_byte(DIRECTED[i].d, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].ok);

		// random streams under a run of profiles, extremes included;
		// every profile change waits for the result side to empty first
		set_profile(24'd48000, 4'd2);
		random_phase();
		set_profile(24'd44100, 4'd1);
		random_phase();
		calm = 1'b1;                       // one phase with no idling at all
		set_profile(24'd0, 4'd0);
		random_phase();
		calm = 1'b0;
		set_profile(24'hffffff, 4'd15);
		random_phase();
		for (int p = 0; p < 3; p++) begin
			set_profile(($urandom_range(0, 1) == 0) ? STD_RATES[$urandom_range(0, 12)]
				: 24'($urandom), 4'($urandom_range(0, 15)));
			random_phase();
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d items over 8 register profiles; %0d verdicts checked (%0d pass).",
			bytes_sent, verdicts_seen, verdicts_ok);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// hard stop in case a handshake hangs
	initial begin
		#(LIMIT_NS);
		$display("Timeout with %0d verdicts still pending", verdict_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
